>>> src/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects a clock named clock
// and a synchronous active-high reset named reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TSS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TSS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/tss_pkg.sv
`timescale 1ns / 1ps

package tss_pkg;

   localparam int ID_W     = 4;
   localparam int STATUS_W = 3;
   localparam int TICK_W   = 32;
   localparam int SCALE_W  = 16;

   localparam logic [1:0] OP_CREATE     = 2'd0;
   localparam logic [1:0] OP_RESCHEDULE = 2'd1;
   localparam logic [1:0] OP_DELETE     = 2'd2;
   localparam logic [1:0] OP_RUN        = 2'd3;

   localparam logic [STATUS_W-1:0] ST_CREATED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DONE    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EXPIRED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NONE    = 3'd5;

   // One timer slot as held in the slot memory.
   typedef struct packed {
      logic [TICK_W-1:0] period;
      logic [TICK_W-1:0] expiry;
   } slot_entry_type;

endpackage

>>> src/tss_slot_ram.sv
`timescale 1ns / 1ps

module tss_slot_ram
   import tss_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  slot_entry_type       wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output slot_entry_type       rd_data
);

   slot_entry_type mem [DEPTH];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/timer_slot_scheduler_core.sv
`timescale 1ns / 1ps
// Channel | Dir | Handshake         | Contents
// req_    | in  | req_tvalid/tready | tuser: operation; tdata: slot, delay_ms, periodic, now
// rsp_    | out | rsp_tvalid/tready | tuser: status; tdata: slot_id; tlast: last
// csr_    | in  | csr_wr_en         | csr_wr_data: ticks_per_ms
//
// One transaction is taken at a time. Delete and reschedule go through the execute and
// reply states, create walks the in-use bits one slot per cycle, and run streams the slot
// memory one slot per cycle while a response stall does not hold the scan. A stall on the
// response side holds the block whenever a new response is ready to load. Reset is
// synchronous: every slot becomes free and the scale returns to 1. No transaction is
// accepted until the last response is loaded.

`include "assert_macros.svh"

module timer_slot_scheduler_core
   import tss_pkg::*;
#(
   parameter int SLOT_COUNT = 16
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_tuser,   // [1:0] operation
   input  logic [71:0]         req_tdata,   // [3:0] slot, [35:4] delay_ms,
                                            // [36] periodic, [68:37] now, rest zero

   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [STATUS_W-1:0] rsp_tuser,   // [2:0] status
   output logic [7:0]          rsp_tdata,   // [3:0] slot_id, rest zero
   output logic                rsp_tlast,

   input  logic                csr_wr_en,
   input  logic [SCALE_W-1:0]  csr_wr_data
);

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOT_COUNT);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOT_COUNT - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_FIND,
      S_REPLY,
      S_SCAN,
      S_FINAL
   } state_type;

   // Request fields.
   logic [ID_W-1:0]   req_slot;
   logic [TICK_W-1:0] req_delay_ms;
   logic              req_periodic;
   logic [TICK_W-1:0] req_now;

   assign req_slot     = req_tdata[3:0];
   assign req_delay_ms = req_tdata[35:4];
   assign req_periodic = req_tdata[36];
   assign req_now      = req_tdata[68:37];

   state_type                 state_ff;
   logic [SCALE_W-1:0]        scale_ff;
   logic [SLOT_COUNT-1:0]     in_use_ff;

   logic [1:0]                op_ff;
   logic [ID_W-1:0]           slot_ff;
   logic                      periodic_ff;
   logic [TICK_W-1:0]         now_ff;
   logic [TICK_W-1:0]         prod_ff;

   logic [STATUS_W-1:0]       reply_status_ff;
   logic [ID_W-1:0]           reply_id_ff;

   // Scan pipeline: rd_idx_ff is the next slot to read (also the create walk
   // counter), chk_* is the slot whose memory word is in the read register.
   logic [CNT_W-1:0]          rd_idx_ff;
   logic                      chk_valid_ff;
   logic [SLOT_W-1:0]         chk_idx_ff;

   // An expired slot is parked here until the scan knows whether another one
   // follows, which decides its tlast.
   logic                      hold_valid_ff;
   logic [ID_W-1:0]           hold_id_ff;

   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [ID_W-1:0]           rsp_id_ff;
   logic                      rsp_last_ff;

   // Memory ports.
   logic                      mem_we;
   logic [SLOT_W-1:0]         mem_waddr;
   slot_entry_type            mem_wdata;
   logic                      mem_re;
   logic [SLOT_W-1:0]         mem_raddr;
   slot_entry_type            mem_rdata;

   logic [SCALE_W+TICK_W-1:0] prod_full;
   logic [TICK_W-1:0]         arm_expiry;
   slot_entry_type            arm_entry;
   logic [TICK_W-1:0]         diff;
   logic                      expired;
   logic                      out_busy;
   logic                      scan_stall;
   logic                      rd_more;
   logic                      slot_ok;
   logic [SLOT_W-1:0]         slot_idx;
   logic                      resched_ok;
   logic [SLOT_W-1:0]         find_idx;
   logic                      find_free;
   logic [6:0]                find_id_wide;
   logic [6:0]                chk_id_wide;

   logic                      out_load;
   logic [STATUS_W-1:0]       out_status;
   logic [ID_W-1:0]           out_id;
   logic                      out_last;

   tss_slot_ram #(
      .DEPTH  (SLOT_COUNT),
      .ADDR_W (SLOT_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // The delay product is taken as the transaction is accepted; only its low
   // 32 bits matter since delays wrap modulo 2^32.
   assign prod_full = req_delay_ms * scale_ff;

   assign arm_expiry       = now_ff + prod_ff;
   assign arm_entry.expiry = arm_expiry;
   assign arm_entry.period = periodic_ff ? prod_ff : '0;

   // A slot in use has expired when the wrapping difference is negative.
   assign diff    = mem_rdata.expiry - now_ff;
   assign expired = chk_valid_ff && in_use_ff[chk_idx_ff] && diff[TICK_W-1];

   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign scan_stall = expired && hold_valid_ff && out_busy;
   assign rd_more    = rd_idx_ff < CNT_END;

   assign slot_ok    = 7'(slot_ff) < 7'(SLOT_COUNT);
   assign slot_idx   = SLOT_W'(slot_ff);
   assign resched_ok = slot_ok && in_use_ff[slot_idx];

   assign find_idx     = rd_idx_ff[SLOT_W-1:0];
   assign find_free    = !in_use_ff[find_idx];
   assign find_id_wide = 7'(find_idx);
   assign chk_id_wide  = 7'(chk_idx_ff);

   // Memory access. During a scan the write always targets the slot being
   // checked and the read the slot after it, so the two never meet.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = arm_entry;
      mem_re    = 1'b0;
      mem_raddr = rd_idx_ff[SLOT_W-1:0];
      case (state_ff)
         S_EXEC: begin
            if (op_ff == OP_RESCHEDULE && resched_ok) begin
               mem_we    = 1'b1;
               mem_waddr = slot_idx;
            end
         end
         S_FIND: begin
            if (find_free) begin
               mem_we    = 1'b1;
               mem_waddr = find_idx;
            end
         end
         S_SCAN: begin
            mem_re = !scan_stall && rd_more;
            if (expired && !scan_stall && mem_rdata.period != '0) begin
               mem_we           = 1'b1;
               mem_waddr        = chk_idx_ff;
               mem_wdata.expiry = now_ff + mem_rdata.period;
               mem_wdata.period = mem_rdata.period;
            end
         end
         default: begin
         end
      endcase
   end

   // Response register load.
   always_comb begin
      out_load   = 1'b0;
      out_status = reply_status_ff;
      out_id     = reply_id_ff;
      out_last   = 1'b1;
      case (state_ff)
         S_REPLY: begin
            out_load = !out_busy;
         end
         S_SCAN: begin
            // A second expired slot pushes the parked one out as not last.
            out_load   = expired && hold_valid_ff && !out_busy;
            out_status = ST_EXPIRED;
            out_id     = hold_id_ff;
            out_last   = 1'b0;
         end
         S_FINAL: begin
            out_load   = !out_busy;
            out_status = hold_valid_ff ? ST_EXPIRED : ST_NONE;
            out_id     = hold_valid_ff ? hold_id_ff : '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         scale_ff      <= SCALE_W'(1);
         in_use_ff     <= '0;
         chk_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            scale_ff <= csr_wr_data;
         end

         if (out_load) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= out_status;
            rsp_id_ff     <= out_id;
            rsp_last_ff   <= out_last;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff       <= req_tuser;
                  slot_ff     <= req_slot;
                  periodic_ff <= req_periodic;
                  now_ff      <= req_now;
                  prod_ff     <= prod_full[TICK_W-1:0];
                  state_ff    <= S_EXEC;
               end
            end
            S_EXEC: begin
               rd_idx_ff   <= '0;
               reply_id_ff <= '0;
               case (op_ff)
                  OP_CREATE: begin
                     state_ff <= S_FIND;
                  end
                  OP_RESCHEDULE: begin
                     reply_status_ff <= resched_ok ? ST_DONE : ST_IGNORED;
                     state_ff        <= S_REPLY;
                  end
                  OP_DELETE: begin
                     if (slot_ok) begin
                        in_use_ff[slot_idx] <= 1'b0;
                     end
                     reply_status_ff <= slot_ok ? ST_DONE : ST_IGNORED;
                     state_ff        <= S_REPLY;
                  end
                  OP_RUN: begin
                     chk_valid_ff  <= 1'b0;
                     hold_valid_ff <= 1'b0;
                     state_ff      <= S_SCAN;
                  end
                  default: begin
                     state_ff <= S_IDLE;
                  end
               endcase
            end
            S_FIND: begin
               if (find_free) begin
                  in_use_ff[find_idx] <= 1'b1;
                  reply_status_ff     <= ST_CREATED;
                  reply_id_ff         <= find_id_wide[ID_W-1:0];
                  state_ff            <= S_REPLY;
               end else if (rd_idx_ff == CNT_LAST) begin
                  reply_status_ff <= ST_FULL;
                  state_ff        <= S_REPLY;
               end else begin
                  rd_idx_ff <= rd_idx_ff + CNT_W'(1);
               end
            end
            S_REPLY: begin
               if (!out_busy) begin
                  state_ff <= S_IDLE;
               end
            end
            S_SCAN: begin
               if (!scan_stall) begin
                  chk_valid_ff <= rd_more;
                  chk_idx_ff   <= rd_idx_ff[SLOT_W-1:0];
                  if (rd_more) begin
                     rd_idx_ff <= rd_idx_ff + CNT_W'(1);
                  end
                  if (expired) begin
                     // A zero reload period frees the slot like a one-shot.
                     if (mem_rdata.period == '0) begin
                        in_use_ff[chk_idx_ff] <= 1'b0;
                     end
                     hold_valid_ff <= 1'b1;
                     hold_id_ff    <= chk_id_wide[ID_W-1:0];
                  end
               end
               if (!chk_valid_ff && !rd_more) begin
                  state_ff <= S_FINAL;
               end
            end
            S_FINAL: begin
               if (!out_busy) begin
                  hold_valid_ff <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'b0000, rsp_id_ff};
   assign rsp_tlast  = rsp_last_ff;

   `TSS_ASSERT_IMPL(a_idle_clean, req_tready, !chk_valid_ff && !hold_valid_ff, "scan not idle")
   `TSS_ASSERT_IMPL(a_no_rw_collide, mem_we && mem_re, mem_waddr != mem_raddr, "slot clash")
   `TSS_ASSERT_IMPL(a_load_when_free, out_load, !out_busy, "response overwritten")
   `TSS_ASSERT_NEXT(a_load_shows, out_load, rsp_tvalid, "loaded response not presented")

endmodule

>>> verif/timer_slot_scheduler_core_test.sv
`timescale 1ns / 1ps

// One result as it leaves the block: status, slot index and the end-of-burst flag.
typedef struct packed {
   logic [tss_pkg::STATUS_W-1:0] status;
   logic [tss_pkg::ID_W-1:0]     slot_id;
   logic                         last;
} tss_event_type;

// Mirror of the timer table. It keeps its own slots and scale, works out the
// results of every accepted transaction and matches them against the results
// that the block sends back, oldest first.
class timer_table_mirror #(int SLOTS = 16);
   logic [tss_pkg::SCALE_W-1:0] scale;
   bit                          in_use[SLOTS];
   logic [31:0]                 expiry[SLOTS];
   logic [31:0]                 reload[SLOTS];
   tss_event_type               pending_events[$];
   int                          mismatch_count;
   int                          requests_seen;
   int                          responses_seen;
   int                          expiries_seen;
   int                          refusals_seen;

   function new();
      scale = 16'd1;
      foreach (in_use[i]) begin
         in_use[i] = 1'b0;
         expiry[i] = 32'd0;
         reload[i] = 32'd0;
      end
      mismatch_count = 0;
      requests_seen  = 0;
      responses_seen = 0;
      expiries_seen  = 0;
      refusals_seen  = 0;
   endfunction

   // The period wraps modulo 2^32; a one-shot slot keeps a zero reload.
   function void arm(int s, logic [31:0] delay_ms, logic periodic, logic [31:0] now_tick);
      logic [63:0] product;
      product   = {32'd0, delay_ms} * {48'd0, scale};
      expiry[s] = now_tick + product[31:0];
      reload[s] = periodic ? product[31:0] : 32'd0;
   endfunction

   function void take_request(logic [1:0] op, logic [71:0] data);
      logic [3:0]    slot;
      logic [31:0]   delay_ms;
      logic          periodic;
      logic [31:0]   now_tick;
      logic [31:0]   gap;
      int            free_slot;
      tss_event_type batch[$];
      slot     = data[3:0];
      delay_ms = data[35:4];
      periodic = data[36];
      now_tick = data[68:37];
      requests_seen++;
      case (op)
         tss_pkg::OP_CREATE: begin
            free_slot = -1;
            for (int i = 0; i < SLOTS && free_slot < 0; i++)
               if (!in_use[i]) free_slot = i;
            if (free_slot >= 0) begin
               arm(free_slot, delay_ms, periodic, now_tick);
               in_use[free_slot] = 1'b1;
               batch.push_back('{tss_pkg::ST_CREATED, 4'(free_slot), 1'b0});
            end else begin
               refusals_seen++;
               batch.push_back('{tss_pkg::ST_FULL, 4'd0, 1'b0});
            end
         end
         tss_pkg::OP_RESCHEDULE: begin
            if (int'(slot) < SLOTS && in_use[slot]) begin
               arm(slot, delay_ms, periodic, now_tick);
               batch.push_back('{tss_pkg::ST_DONE, 4'd0, 1'b0});
            end else begin
               batch.push_back('{tss_pkg::ST_IGNORED, 4'd0, 1'b0});
            end
         end
         tss_pkg::OP_DELETE: begin
            if (int'(slot) < SLOTS) begin
               in_use[slot] = 1'b0;
               batch.push_back('{tss_pkg::ST_DONE, 4'd0, 1'b0});
            end else begin
               batch.push_back('{tss_pkg::ST_IGNORED, 4'd0, 1'b0});
            end
         end
         default: begin
            // Scan in index order; a slot has expired when the wrapped
            // difference to the current tick is negative.
            for (int i = 0; i < SLOTS; i++) begin
               if (in_use[i]) begin
                  gap = expiry[i] - now_tick;
                  if (gap[31]) begin
                     expiries_seen++;
                     batch.push_back('{tss_pkg::ST_EXPIRED, 4'(i), 1'b0});
                     if (reload[i] != 32'd0) expiry[i] = now_tick + reload[i];
                     else in_use[i] = 1'b0;
                  end
               end
            end
            if (batch.size() == 0)
               batch.push_back('{tss_pkg::ST_NONE, 4'd0, 1'b0});
         end
      endcase
      foreach (batch[i]) begin
         batch[i].last = (i == batch.size() - 1);
         pending_events.push_back(batch[i]);
      end
   endfunction

   function void match_response(logic [2:0] status, logic [7:0] data, logic last);
      tss_event_type want;
      responses_seen++;
      if (pending_events.size() == 0) begin
         $error("result with status %0d, slot_id %0d arrived with nothing outstanding",
                status, data[3:0]);
         mismatch_count++;
         return;
      end
      want = pending_events.pop_front();
      if (status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, status);
         mismatch_count++;
      end
      if (data[3:0] !== want.slot_id) begin
         $error("slot_id: expected %0d, actual %0d", want.slot_id, data[3:0]);
         mismatch_count++;
      end
      if (last !== want.last) begin
         $error("last: expected %0d, actual %0d", want.last, last);
         mismatch_count++;
      end
      if (data[7:4] !== 4'd0) begin
         $error("rsp_tdata padding: expected 0, actual %0h", data[7:4]);
         mismatch_count++;
      end
   endfunction

   function int random_busy_slot();
      int busy[$];
      foreach (in_use[i])
         if (in_use[i]) busy.push_back(i);
      if (busy.size() == 0) return -1;
      return busy[$urandom_range(busy.size() - 1)];
   endfunction
endclass

// Top level of the timer slot scheduler test.
//
// The block takes one request transaction at a time and answers with one or
// more result transactions, the final one flagged by rsp_tlast. A mirror object
// watches every accepted transaction on both channels: requests update its copy
// of the slot table and queue the expected results, and every accepted result
// is compared field by field with the oldest one queued.
//
// The run starts with a short directed sequence that covers an empty scan,
// periodic slots whose period comes out as zero (zero delay, zero scale and a
// product that wraps to zero), rescheduling a free slot, deleting a free slot,
// the sign boundary of the wrapped tick difference, and the extreme field
// values. Random phases follow, each with its own scale and idling pattern.
module timer_slot_scheduler_core_test;
   import tss_pkg::*;

   localparam int SLOTS           = 16;
   // Longest stretch without any accepted transaction before the run is
   // declared hung. The deliberate receiver hold-off is well below it.
   localparam int QUIET_LIMIT     = 5000;
   localparam int HOLD_CYCLES     = 400;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int PHASE_COUNT     = 4;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [1:0]          req_tuser   = 2'd0;
   logic [71:0]         req_tdata   = 72'd0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [STATUS_W-1:0] rsp_tuser;
   logic [7:0]          rsp_tdata;
   logic                rsp_tlast;
   logic                csr_wr_en   = 1'b0;
   logic [SCALE_W-1:0]  csr_wr_data = 16'd1;

   // Idling controls, changed between phases by the stimulus process.
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   bit          hold_rsp      = 1'b0;
   logic [31:0] tick_count    = 32'd0;

   timer_table_mirror #(SLOTS) mirror;

   always #4 clock = ~clock;

   timer_slot_scheduler_core #(
      .SLOT_COUNT (SLOTS)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Both channels are sampled in one process, so a request is always noted
   // before any result that could follow from it is checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) mirror.take_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) mirror.match_response(rsp_tuser, rsp_tdata, rsp_tlast);
      end
   end

   // Receiver. It stalls at the current rate, and on request it holds off for
   // a long stretch so that the block fills up and stops taking requests.
   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog: any accepted transaction on either channel restarts the count.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("Mismatches found");
      $finish;
   end

   // Offers one request and returns at the edge where it is accepted. The
   // valid stays high so that a following request goes out back to back.
   task automatic send_request(logic [1:0] op, logic [3:0] slot, logic [31:0] delay_ms,
                               logic periodic, logic [31:0] now_tick);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'd0, now_tick, periodic, delay_ms, slot};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering and waits until every expected result has come back. The
   // first edge lets the monitor note the request accepted at this edge.
   task automatic stop_sending();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (mirror.pending_events.size() != 0) @(posedge clock);
   endtask

   // Writes the scale once the block is idle. Every request gives at least
   // one result, so the extra cycles only cover the block's own wind-down.
   task automatic write_scale(logic [SCALE_W-1:0] value);
      stop_sending();
      repeat (SLOTS + 8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      mirror.scale  = value;
   endtask

   // Mostly a well-formed timeline: the tick moves forward by a few scaled
   // steps and delays are short, so slots really expire and reload. About one
   // request in twenty jumps the tick and uses a full-width delay.
   task automatic random_request();
      int          pick;
      int          busy;
      bit          noise;
      logic [1:0]  op;
      logic [3:0]  slot;
      logic [31:0] delay_ms;
      logic [31:0] step;
      pick  = $urandom_range(99);
      noise = ($urandom_range(19) == 0);
      step  = (mirror.scale == 0) ? 32'd1 : 32'(mirror.scale);
      if (noise) tick_count = $urandom;
      else tick_count += $urandom_range(6) * step + $urandom_range(2);
      delay_ms = noise ? 32'($urandom) : 32'($urandom_range(12));
      slot     = 4'($urandom_range(15));
      if (pick < 40) op = OP_CREATE;
      else if (pick < 58) op = OP_RESCHEDULE;
      else if (pick < 72) op = OP_DELETE;
      else op = OP_RUN;
      if ((op == OP_RESCHEDULE || op == OP_DELETE) && $urandom_range(3) != 0) begin
         busy = mirror.random_busy_slot();
         if (busy >= 0) slot = 4'(busy);
      end
      send_request(op, slot, delay_ms, 1'($urandom_range(1)), tick_count);
   endtask

   initial begin
      int phase_scale[PHASE_COUNT];
      int phase_idle[PHASE_COUNT];
      int phase_stall[PHASE_COUNT];
      phase_scale = '{3, 65535, 1, 17};
      phase_idle  = '{0, 87, 0, 10};
      phase_stall = '{0, 0, 87, 10};
      mirror = new();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the scale at 1: empty scan, zero-period and
      // full-width periodic slots, a one-shot slot, rescheduling a free slot,
      // deleting a free slot, and the sign boundary of the tick difference.
      write_scale(16'd1);
      send_request(OP_RUN,        4'hF, 32'd0,         1'b1, 32'd0);
      send_request(OP_CREATE,     4'hA, 32'd0,         1'b1, 32'd100);
      send_request(OP_CREATE,     4'h5, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      send_request(OP_CREATE,     4'h0, 32'd5,         1'b0, 32'd0);
      send_request(OP_RESCHEDULE, 4'd3, 32'd7,         1'b1, 32'd0);
      send_request(OP_RESCHEDULE, 4'd2, 32'd10,        1'b1, 32'd0);
      send_request(OP_RUN,        4'd0, 32'd0,         1'b0, 32'd101);
      send_request(OP_DELETE,     4'hF, 32'd0,         1'b0, 32'd0);
      send_request(OP_DELETE,     4'd1, 32'd0,         1'b0, 32'd0);
      send_request(OP_CREATE,     4'd0, 32'd1,         1'b0, 32'h7FFF_FFFF);
      send_request(OP_RUN,        4'd0, 32'd0,         1'b0, 32'h8000_0000);
      send_request(OP_RUN,        4'd0, 32'd0,         1'b0, 32'h8000_0001);

      // A zero scale gives a zero period, so the periodic slot is freed.
      write_scale(16'd0);
      send_request(OP_CREATE,     4'd0, 32'hFFFF_FFFF, 1'b1, 32'd5);
      send_request(OP_RUN,        4'd0, 32'd0,         1'b0, 32'd6);

      // A product of exactly 2^32 wraps to a zero period.
      write_scale(16'h8000);
      send_request(OP_CREATE,     4'd0, 32'h0002_0000, 1'b1, 32'd0);
      send_request(OP_RUN,        4'd0, 32'd0,         1'b0, 32'd1);

      // Largest scale with full-width delays and ticks.
      write_scale(16'hFFFF);
      send_request(OP_CREATE,     4'd0, 32'hFFFF_FFFF, 1'b1, 32'd0);
      send_request(OP_RESCHEDULE, 4'd2, 32'hFFFF_FFFF, 1'b0, 32'h1234_5678);
      send_request(OP_RUN,        4'hF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);

      // Random phases. Each phase sets its own scale and idling pattern. The
      // first has no idling but a long receiver hold-off; every phase pauses
      // the sender once until all of its results have come back.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_scale(16'(phase_scale[p]));
         send_idle_pct = phase_idle[p];
         rsp_stall_pct = phase_stall[p];
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 0 && n == 30) hold_rsp = 1'b1;
            if (n == 50) stop_sending();
            random_request();
         end
      end

      stop_sending();
      repeat (SLOTS + 8) @(posedge clock);

      $display("Covered %0d request and %0d result transactions, %0d expiries, %0d refusals.",
               mirror.requests_seen, mirror.responses_seen, mirror.expiries_seen,
               mirror.refusals_seen);
      $display("Scales from 0 to 65535 were used with four idling patterns.");
      if (mirror.mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
